// ----- hw/rtl/grfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package grfa_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int ROWS_DEF        = 64;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [4:0] COLUMNS_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_FIRST_FIT = 2'd0,
    KIND_AT_TILE   = 2'd1,
    KIND_FREE      = 2'd2,
    KIND_LOCATE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] item_id;
    logic [3:0]  tile_x;
    logic [5:0]  tile_y;
    logic [4:0]  item_width;
    logic [6:0]  item_height;
  } in_req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] result_x;
    logic [5:0] result_y;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DECIDE,
    ST_CHECK_RD,
    ST_CHECK_WAIT,
    ST_CHECK_EVAL,
    ST_FILL,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_EVAL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/grfa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module grfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/grid_rectangle_first_fit_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Occupancy-grid allocator over one single-port-read cell memory, one cell access at a time.
// After reset a clearing pass zeroes every cell of the grid; no request is taken meanwhile.
// A place-at-tile request reads and checks each cell of its rectangle, then fills them if
// all are free. First-fit checks each candidate corner in scan order. Free sweeps the whole
// store, and locate sweeps the cells in use until the first match. Each cell is read through
// the registered read port of the cell memory. A finished result waits in an output register,
// so the next request is taken and worked on while it waits; the block holds in its last
// step until that result has left. Configuration must be written only while idle.
module grid_rectangle_first_fit_allocator
  import grfa_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_res_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int CELLS = MAX_COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int YW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Wide enough for x/y sums of input fields and bounds.
  localparam int SW    = ((YW > 7) ? YW : 7) + 2;

  logic [4:0]  columns_r;
  state_t      state_r, state_nxt;
  in_req_t     req_r;
  logic [ID_BITS-1:0] id_r;
  logic [CW-1:0] cols_r;
  // candidate corner and offsets inside the rectangle
  logic [SW-1:0] cx_r, cy_r, ox_r, oy_r;
  logic [AW:0]   idx_r;
  logic [AW-1:0] addr_r;
  logic          hit_r;
  logic          res_valid_r;
  out_res_t      res_r;

  logic [ID_BITS-1:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [ID_BITS-1:0] wdata;

  grfa_ram #(.WIDTH(ID_BITS), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Clamped column count.
  logic [CW-1:0] cols_use;
  always_comb begin
    if (columns_r == 5'd0) begin
      cols_use = CW'(1);
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      cols_use = CW'(MAX_COLUMNS);
    end else begin
      cols_use = CW'(columns_r);
    end
  end

  logic [SW-1:0] w_s, h_s, px, py;
  logic [AW+SW:0] cell_lin;
  logic          fits;
  logic          last_ox, last_oy;
  logic [AW:0]   used;
  assign w_s  = SW'(req_r.item_width);
  assign h_s  = SW'(req_r.item_height);
  assign px   = cx_r + ox_r;
  assign py   = cy_r + oy_r;
  assign cell_lin = (AW+SW+1)'(py) * (AW+SW+1)'(cols_r) + (AW+SW+1)'(px);
  assign fits = (w_s != '0) && (h_s != '0) &&
                ((32'(cx_r) + 32'(w_s)) <= 32'(cols_r)) &&
                ((32'(cy_r) + 32'(h_s)) <= ROWS);
  assign last_ox = (ox_r + 1'b1) == w_s;
  assign last_oy = (oy_r + 1'b1) == h_s;
  assign used    = (AW+1)'(cols_r) * (AW+1)'(ROWS);

  logic last_corner;
  assign last_corner = ((cx_r + 1'b1) == SW'(cols_r)) && ((cy_r + 1'b1) == SW'(ROWS));

  // The result register takes a new result once the old one is gone or leaving.
  logic post_res;
  assign post_res = (state_r == ST_DONE) && (!res_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_DECIDE;
      ST_CLEAR:      if (idx_r == (AW+1)'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_DECIDE: begin
        priority if (id_r == '0) state_nxt = ST_DONE;
        else if (req_r.kind == KIND_FREE || req_r.kind == KIND_LOCATE)
          state_nxt = ST_SCAN_RD;
        else if (fits) state_nxt = ST_CHECK_RD;
        else if (req_r.kind == KIND_AT_TILE || last_corner) state_nxt = ST_DONE;
        else state_nxt = ST_DECIDE;
      end
      ST_CHECK_RD:   state_nxt = ST_CHECK_WAIT;
      ST_CHECK_WAIT: state_nxt = ST_CHECK_EVAL;
      ST_CHECK_EVAL: begin
        priority if (rdata != '0) begin
          if (req_r.kind == KIND_AT_TILE || last_corner) state_nxt = ST_DONE;
          else state_nxt = ST_DECIDE;
        end else if (last_ox && last_oy) state_nxt = ST_FILL;
        else state_nxt = ST_CHECK_RD;
      end
      ST_FILL:       if (last_ox && last_oy) state_nxt = ST_DONE;
      ST_SCAN_RD:    state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT:  state_nxt = ST_SCAN_EVAL;
      ST_SCAN_EVAL: begin
        priority if (req_r.kind == KIND_LOCATE &&
                     (rdata == id_r || idx_r + 1'b1 >= used)) state_nxt = ST_DONE;
        else if (req_r.kind == KIND_FREE && idx_r == (AW+1)'(CELLS - 1))
          state_nxt = ST_DONE;
        else state_nxt = ST_SCAN_RD;
      end
      ST_DONE:       if (post_res) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    raddr = addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = idx_r[AW-1:0];
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = AW'(cell_lin);
        wdata = id_r;
      end
      ST_SCAN_EVAL: begin
        we    = (req_r.kind == KIND_FREE) && (rdata == id_r);
        waddr = addr_r;
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      columns_r   <= COLUMNS_RESET;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) columns_r <= cfg_wdata;
      if (post_res) res_valid_r <= 1'b1;
      else if (out_valid && out_ready) res_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: idx_r <= idx_r + 1'b1;
        ST_IDLE: if (in_valid && in_ready) begin
          req_r  <= in_data;
          id_r   <= ID_BITS'(in_data.item_id);
          cols_r <= cols_use;
          hit_r  <= 1'b0;
          idx_r  <= '0;
          ox_r   <= '0;
          oy_r   <= '0;
          if (in_data.kind == KIND_AT_TILE) begin
            cx_r <= SW'(in_data.tile_x);
            cy_r <= SW'(in_data.tile_y);
          end else begin
            cx_r <= '0;
            cy_r <= '0;
          end
        end
        ST_DECIDE: begin
          addr_r <= '0;
          if (id_r != '0 && req_r.kind == KIND_FIRST_FIT && !fits && !last_corner) begin
            if ((cx_r + 1'b1) == SW'(cols_r)) begin
              cx_r <= '0;
              cy_r <= cy_r + 1'b1;
            end else begin
              cx_r <= cx_r + 1'b1;
            end
          end
        end
        ST_CHECK_RD: addr_r <= AW'(cell_lin);
        ST_CHECK_EVAL: begin
          if (rdata != '0) begin
            ox_r <= '0;
            oy_r <= '0;
            if (req_r.kind == KIND_FIRST_FIT && !last_corner) begin
              if ((cx_r + 1'b1) == SW'(cols_r)) begin
                cx_r <= '0;
                cy_r <= cy_r + 1'b1;
              end else begin
                cx_r <= cx_r + 1'b1;
              end
            end
          end else if (last_ox && last_oy) begin
            ox_r  <= '0;
            oy_r  <= '0;
            hit_r <= 1'b1;
          end else if (last_ox) begin
            ox_r <= '0;
            oy_r <= oy_r + 1'b1;
          end else begin
            ox_r <= ox_r + 1'b1;
          end
        end
        ST_FILL: begin
          if (last_ox) begin
            ox_r <= '0;
            oy_r <= oy_r + 1'b1;
          end else begin
            ox_r <= ox_r + 1'b1;
          end
        end
        ST_SCAN_RD: addr_r <= idx_r[AW-1:0];
        ST_SCAN_EVAL: begin
          if (rdata == id_r) begin
            hit_r <= 1'b1;
          end
          if (!(req_r.kind == KIND_LOCATE && rdata == id_r)) begin
            idx_r <= idx_r + 1'b1;
            if (cx_r + 1'b1 == SW'(cols_r)) begin
              cx_r <= '0;
              cy_r <= cy_r + 1'b1;
            end else begin
              cx_r <= cx_r + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (post_res) begin
            res_r.ok <= hit_r;
            if (hit_r && req_r.kind != KIND_FREE) begin
              res_r.result_x <= cx_r[3:0];
              res_r.result_y <= cy_r[5:0];
            end else begin
              res_r.result_x <= '0;
              res_r.result_y <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("request taken while busy");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("result not posted");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import grfa_pkg::*;

  localparam int NCOLS = 16;
  localparam int NROWS = 64;
  localparam int NCELLS = NCOLS * NROWS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  grid_rectangle_first_fit_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow of the occupancy grid and the column register.
  logic [15:0] shadow_grid [NCELLS];
  logic [4:0] shadow_columns;
  out_res_t placement_queue [$];
  int fail_count = 0;
  int accepted_count = 0;
  bit quiet = 1'b0;
  bit pressure_done = 1'b0;

  function automatic bit region_empty(int x, int y, int w, int h, int cols);
    if (w == 0 || h == 0) return 1'b0;
    if (x + w > cols || y + h > NROWS) return 1'b0;
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++)
        if (shadow_grid[(y + j) * cols + x + i] != 16'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void region_claim(logic [15:0] id, int x, int y, int w, int h, int cols);
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++)
        shadow_grid[(y + j) * cols + x + i] = id;
  endfunction

  function automatic out_res_t allocate(in_req_t r);
    out_res_t res;
    int cols;
    int w;
    int h;
    res = '0;
    cols = (shadow_columns == 0) ? 1 : (shadow_columns > NCOLS) ? NCOLS : int'(shadow_columns);
    w = r.item_width;
    h = r.item_height;
    if (r.item_id != 16'd0) begin
      case (kind_t'(r.kind))
        KIND_FIRST_FIT: begin
          for (int i = 0; i < cols * NROWS; i++) begin
            if (region_empty(i % cols, i / cols, w, h, cols)) begin
              region_claim(r.item_id, i % cols, i / cols, w, h, cols);
              res.ok = 1'b1;
              res.result_x = 4'(i % cols);
              res.result_y = 6'(i / cols);
              break;
            end
          end
        end
        KIND_AT_TILE: begin
          if (region_empty(r.tile_x, r.tile_y, w, h, cols)) begin
            region_claim(r.item_id, r.tile_x, r.tile_y, w, h, cols);
            res.ok = 1'b1;
            res.result_x = r.tile_x;
            res.result_y = r.tile_y;
          end
        end
        KIND_FREE: begin
          for (int i = 0; i < NCELLS; i++) begin
            if (shadow_grid[i] == r.item_id) begin
              shadow_grid[i] = 16'd0;
              res.ok = 1'b1;
            end
          end
        end
        default: begin
          for (int i = 0; i < cols * NROWS; i++) begin
            if (shadow_grid[i] == r.item_id) begin
              res.ok = 1'b1;
              res.result_x = 4'(i % cols);
              res.result_y = 6'(i / cols);
              break;
            end
          end
        end
      endcase
    end
    return res;
  endfunction

  function automatic in_req_t make_req(kind_t k, logic [15:0] id, int x, int y, int w, int h);
    in_req_t r;
    r.kind = k;
    r.item_id = id;
    r.tile_x = 4'(x);
    r.tile_y = 6'(y);
    r.item_width = 5'(w);
    r.item_height = 7'(h);
    return r;
  endfunction

  // Offers one request; the previous one stays on the bus until this call starts.
  task automatic send_request(in_req_t r, bit typed, out_res_t typed_res);
    out_res_t predicted;
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    predicted = allocate(r);
    placement_queue.push_back(typed ? typed_res : predicted);
    accepted_count++;
  endtask

  task automatic drain_and_set_columns(logic [4:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (placement_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    shadow_columns = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_req_t random_req();
    int sel;
    logic [15:0] id;
    kind_t k;
    int w;
    int h;
    sel = $urandom_range(0, 99);
    id = (sel < 85) ? 16'($urandom_range(1, 12)) : (sel < 95) ? 16'($urandom) : 16'd0;
    sel = $urandom_range(0, 99);
    k = (sel < 40) ? KIND_FIRST_FIT : (sel < 65) ? KIND_AT_TILE :
        (sel < 80) ? KIND_FREE : KIND_LOCATE;
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    // Large or degenerate sizes only where the check cost stays bounded.
    if (k == KIND_AT_TILE && $urandom_range(0, 4) == 0) begin
      w = $urandom_range(0, 31);
      h = $urandom_range(0, 127);
    end else if (k == KIND_FIRST_FIT && $urandom_range(0, 19) == 0) begin
      w = $urandom_range(0, 16);
      h = $urandom_range(0, 2);
    end
    return make_req(k, id, $urandom_range(0, 15), $urandom_range(0, 63), w, h);
  endfunction

  typedef struct {
    in_req_t req;
    bit typed;
    out_res_t res;
  } stim_row_t;

  stim_row_t directed [$];

  task automatic add_row(in_req_t r, bit typed, bit ok, int x, int y);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.res.ok = ok;
    row.res.result_x = 4'(x);
    row.res.result_y = 6'(y);
    directed.push_back(row);
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (placement_queue.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        want = placement_queue.pop_front();
        if (out_data.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, out_data.ok);
          fail_count++;
        end
        if (out_data.result_x !== want.result_x) begin
          $error("result_x: expected %0d, actual %0d", want.result_x, out_data.result_x);
          fail_count++;
        end
        if (out_data.result_y !== want.result_y) begin
          $error("result_y: expected %0d, actual %0d", want.result_y, out_data.result_y);
          fail_count++;
        end
      end
    end
  end

  // Result side back-pressure, with one long hold-off that fills the block.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!pressure_done && accepted_count >= 150) begin
        out_ready = 1'b0;
        repeat (4000) @(negedge clk);
        pressure_done = 1'b1;
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #1500ms;
    $display("grid_rectangle_first_fit_allocator test failed");
    $finish;
  end

  initial begin
    logic [4:0] phase_columns [6] = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd12, 5'd16};
    foreach (shadow_grid[i]) shadow_grid[i] = 16'd0;
    shadow_columns = COLUMNS_RESET;

    add_row(make_req(KIND_LOCATE, 16'd5, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FREE, 16'd5, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'd0, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'd1, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'd2, 0, 0, 0, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'd2, 0, 0, 1, 0), 1, 0, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'hFFFF, 15, 63, 1, 1), 1, 1, 15, 63);
    add_row(make_req(KIND_AT_TILE, 16'd3, 15, 0, 2, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'd3, 0, 63, 1, 2), 1, 0, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'd3, 0, 0, 31, 127), 1, 0, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'd0, 4, 4, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_LOCATE, 16'hFFFF, 0, 0, 1, 1), 1, 1, 15, 63);
    add_row(make_req(KIND_LOCATE, 16'd0, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'd4, 0, 0, 16, 2), 0, 0, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'd5, 0, 0, 16, 64), 1, 0, 0, 0);
    add_row(make_req(KIND_FREE, 16'hFFFF, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_FREE, 16'hFFFF, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FREE, 16'd0, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_FREE, 16'd1, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_FREE, 16'd4, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'hAAAA, 0, 0, 16, 64), 1, 1, 0, 0);
    add_row(make_req(KIND_FIRST_FIT, 16'h5555, 0, 0, 1, 1), 1, 0, 0, 0);
    add_row(make_req(KIND_LOCATE, 16'hAAAA, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_FREE, 16'hAAAA, 0, 0, 1, 1), 1, 1, 0, 0);
    add_row(make_req(KIND_AT_TILE, 16'h5555, 10, 40, 6, 24), 1, 1, 10, 40);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);

    foreach (phase_columns[p]) begin
      drain_and_set_columns(phase_columns[p]);
      for (int n = 0; n < 93; n++) begin
        // The tail of the run goes without any idling.
        if (p == 5 && n == 40) quiet = 1'b1;
        send_request(random_req(), 0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (placement_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && placement_queue.size() == 0) begin
      $display("grid_rectangle_first_fit_allocator test passed");
    end else begin
      $display("grid_rectangle_first_fit_allocator test failed");
    end
    $finish;
  end

endmodule
